[rtl/core/pid_pkg.sv]
// Shared types, constants and helper functions for the personal ID validator.
// No dependencies; every rtl/core module refers into this package by scoped names.
package pid_pkg;

   // Input and binary-to-decimal conversion geometry
   localparam int PID_IN_W       = 34;
   localparam int PID_STEP       = 6;                       // shift-add-3 steps per stage
   localparam int PID_BCD_STAGES = 6;
   localparam int PID_BIN_W      = PID_STEP * PID_BCD_STAGES; // zero-padded binary width
   localparam int PID_BCD_DIGITS = 11;                      // enough for 2^34 - 1
   localparam int PID_BCD_W      = 4 * PID_BCD_DIGITS;
   localparam int PID_ID_DIGITS  = 10;
   localparam int PID_WSUM_W     = 9;                       // max weighted sum 486

   // Weights for digits one to nine of the check sum
   localparam int PID_NUM_WEIGHTS = 9;
   localparam logic [3:0] PID_WEIGHT [0:PID_NUM_WEIGHTS-1] =
      '{4'd2, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9, 4'd7, 4'd3, 4'd6};

   // Modulo 11 by reciprocal: q = (x * 373) >> 12, exact for x <= 486
   localparam int PID_MOD        = 11;
   localparam int PID_MOD_RECIP  = 373;
   localparam int PID_MOD_SHIFT  = 12;
   localparam int PID_MOD_PROD_W = 18;
   localparam int PID_QUOT_W     = PID_MOD_PROD_W - PID_MOD_SHIFT;
   localparam logic [3:0] PID_CHK_WRAP = 4'd10;             // remainder ten maps to zero

   // Month encoding and centuries
   localparam logic [6:0]  PID_MONTH_2000S = 7'd40;
   localparam logic [6:0]  PID_MONTH_1800S = 7'd20;
   localparam logic [11:0] PID_BASE_2000   = 12'd2000;
   localparam logic [11:0] PID_BASE_1800   = 12'd1800;
   localparam logic [11:0] PID_BASE_1900   = 12'd1900;
   localparam logic [5:0]  PID_MONTH_FEB   = 6'd2;
   localparam logic [5:0]  PID_MONTH_DEC   = 6'd12;

   typedef struct packed {
      logic [PID_BIN_W-1:0] bin;
      logic [PID_BCD_W-1:0] bcd;
   } pid_conv_type;

   typedef struct packed {
      logic [6:0]            year2;
      logic [6:0]            month_raw;
      logic [6:0]            day;
      logic [PID_WSUM_W-1:0] wsum;
      logic [3:0]            chk;
      logic                  female;
   } pid_dec_type;

   typedef struct packed {
      logic [6:0]            day;
      logic [5:0]            month;
      logic [11:0]           year;
      logic                  leap;
      logic [PID_WSUM_W-1:0] wsum;
      logic [PID_QUOT_W-1:0] quot;
      logic [3:0]            chk;
      logic                  female;
   } pid_cen_type;

   typedef struct packed {
      logic        valid_res;
      logic [6:0]  day;
      logic [5:0]  month;
      logic [11:0] year;
      logic        female;
   } pid_res_type;

   // Days in a month; zero for a month code outside one to twelve
   function automatic logic [4:0] pid_max_day(input logic [5:0] month, input logic leap);
      logic [4:0] days;
      case (month) inside
         6'd1, 6'd3, 6'd5, 6'd7, 6'd8, 6'd10, 6'd12: days = 5'd31;
         6'd4, 6'd6, 6'd9, 6'd11:                    days = 5'd30;
         PID_MONTH_FEB:                              days = leap ? 5'd29 : 5'd28;
         default:                                    days = 5'd0;
      endcase
      return days;
   endfunction

endpackage

[rtl/core/pid_bcd_stage.sv]
// One slice of the binary-to-decimal converter: PID_STEP shift-add-3 steps, registered.
// Depends on pid_pkg.
module pid_bcd_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  pid_pkg::pid_conv_type up_data,
   output logic                  up_ready,
   output logic                  down_valid,
   output pid_pkg::pid_conv_type down_data,
   input  logic                  down_ready
);

   logic                  valid_ff;
   pid_pkg::pid_conv_type data_ff;
   pid_pkg::pid_conv_type data_in;

   // Consume the top PID_STEP bits of the binary word into the BCD digits
   always_comb begin
      logic [pid_pkg::PID_BIN_W-1:0] b;
      logic [pid_pkg::PID_BCD_W-1:0] c;
      b = up_data.bin;
      c = up_data.bcd;
      for (int s = 0; s < pid_pkg::PID_STEP; s++) begin
         for (int j = 0; j < pid_pkg::PID_BCD_DIGITS; j++) begin
            if (c[4*j +: 4] >= 4'd5) begin
               c[4*j +: 4] = c[4*j +: 4] + 4'd3;
            end
         end
         c = {c[pid_pkg::PID_BCD_W-2:0], b[pid_pkg::PID_BIN_W-1]};
         b = {b[pid_pkg::PID_BIN_W-2:0], 1'b0};
      end
      data_in.bin = b;
      data_in.bcd = c;
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

[rtl/core/pid_decode.sv]
// Digit decode stage: two-digit year, raw month, day, weighted check sum, check digit, sex bit.
// Depends on pid_pkg.
module pid_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  pid_pkg::pid_conv_type up_data,
   output logic                  up_ready,
   output logic                  down_valid,
   output pid_pkg::pid_dec_type  down_data,
   input  logic                  down_ready
);

   logic                 valid_ff;
   pid_pkg::pid_dec_type data_ff;
   pid_pkg::pid_dec_type data_in;

   always_comb begin
      logic [3:0]                     d [0:pid_pkg::PID_ID_DIGITS-1];
      logic [pid_pkg::PID_WSUM_W-1:0] sum;
      // Digit one is the most significant of the low ten; the eleventh is dropped
      for (int i = 0; i < pid_pkg::PID_ID_DIGITS; i++) begin
         d[i] = up_data.bcd[4*(pid_pkg::PID_ID_DIGITS-1-i) +: 4];
      end
      sum = '0;
      for (int i = 0; i < pid_pkg::PID_NUM_WEIGHTS; i++) begin
         sum = sum + pid_pkg::PID_WSUM_W'(d[i]) *
                     pid_pkg::PID_WSUM_W'(pid_pkg::PID_WEIGHT[i]);
      end
      data_in.year2     = 7'(d[0]) * 7'd10 + 7'(d[1]);
      data_in.month_raw = 7'(d[2]) * 7'd10 + 7'(d[3]);
      data_in.day       = 7'(d[4]) * 7'd10 + 7'(d[5]);
      data_in.wsum      = sum;
      data_in.chk       = d[9];
      data_in.female    = d[8][0];
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

[rtl/core/pid_century.sv]
// Century stage: strip the month offset, build the full year and leap flag,
// and form the modulo-11 quotient by reciprocal multiply. Depends on pid_pkg.
module pid_century (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   input  pid_pkg::pid_dec_type up_data,
   output logic                 up_ready,
   output logic                 down_valid,
   output pid_pkg::pid_cen_type down_data,
   input  logic                 down_ready
);

   logic                 valid_ff;
   pid_pkg::pid_cen_type data_ff;
   pid_pkg::pid_cen_type data_in;

   always_comb begin
      logic [6:0]                         month_adj;
      logic [11:0]                        base;
      logic                               is_2000s;
      logic [pid_pkg::PID_MOD_PROD_W-1:0] prod;
      is_2000s = up_data.month_raw > pid_pkg::PID_MONTH_2000S;
      if (is_2000s) begin
         month_adj = up_data.month_raw - pid_pkg::PID_MONTH_2000S;
         base      = pid_pkg::PID_BASE_2000;
      end else if (up_data.month_raw > pid_pkg::PID_MONTH_1800S) begin
         month_adj = up_data.month_raw - pid_pkg::PID_MONTH_1800S;
         base      = pid_pkg::PID_BASE_1800;
      end else begin
         month_adj = up_data.month_raw;
         base      = pid_pkg::PID_BASE_1900;
      end
      prod = pid_pkg::PID_MOD_PROD_W'(up_data.wsum) *
             pid_pkg::PID_MOD_PROD_W'(pid_pkg::PID_MOD_RECIP);

      data_in.day    = up_data.day;
      data_in.month  = month_adj[5:0];
      data_in.year   = base + 12'(up_data.year2);
      // Every century base is a multiple of four; of the century years only 2000 is leap
      data_in.leap   = (up_data.year2[1:0] == 2'd0) && ((up_data.year2 != 7'd0) || is_2000s);
      data_in.wsum   = up_data.wsum;
      data_in.quot   = prod[pid_pkg::PID_MOD_PROD_W-1:pid_pkg::PID_MOD_SHIFT];
      data_in.chk    = up_data.chk;
      data_in.female = up_data.female;
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

[rtl/core/pid_verdict.sv]
// Final stage and output register: check digit remainder, day range, validity.
// Depends on pid_pkg.
module pid_verdict (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   input  pid_pkg::pid_cen_type up_data,
   output logic                 up_ready,
   output logic                 down_valid,
   output pid_pkg::pid_res_type down_data,
   input  logic                 down_ready
);

   logic                 valid_ff;
   pid_pkg::pid_res_type data_ff;
   pid_pkg::pid_res_type data_in;

   always_comb begin
      logic [pid_pkg::PID_WSUM_W-1:0] q11;
      logic [pid_pkg::PID_WSUM_W-1:0] rem_full;
      logic [3:0]                     chk_calc;
      logic [4:0]                     max_day;
      logic                           month_ok;
      q11      = pid_pkg::PID_WSUM_W'(up_data.quot) * pid_pkg::PID_WSUM_W'(pid_pkg::PID_MOD);
      rem_full = up_data.wsum - q11;
      chk_calc = (rem_full[3:0] == pid_pkg::PID_CHK_WRAP) ? 4'd0 : rem_full[3:0];
      max_day  = pid_pkg::pid_max_day(up_data.month, up_data.leap);
      month_ok = (up_data.month != 6'd0) && (up_data.month <= pid_pkg::PID_MONTH_DEC);

      data_in.valid_res = month_ok && (up_data.day != 7'd0) &&
                          (up_data.day <= 7'(max_day)) && (up_data.chk == chk_calc);
      data_in.day       = up_data.day;
      data_in.month     = up_data.month;
      data_in.year      = up_data.year;
      data_in.female    = up_data.female;
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

[rtl/core/personal_id_validator_unit.sv]
// Top level of the personal ID validator: converter stages, decode, century, verdict.
// Depends on pid_pkg, pid_bcd_stage, pid_decode, pid_century and pid_verdict.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_id_number[33:0]
//   rsp_      out        rsp_valid/rsp_stall   rsp_valid_res, rsp_birth_day[6:0],
//                                              rsp_birth_month[5:0], rsp_birth_year[11:0],
//                                              rsp_is_female
//
// One item enters per cycle while req_stall is low; each result passes through the six
// converter stages, then the decode, century and verdict stages.
// The six converter stages run the shift-add-3 binary-to-decimal split, six steps a stage.
// Synchronous reset clears the valid bit of every stage; payload registers are not reset.
// Each stage holds while it is full and the next one is held; empty stages keep filling,
// so a stall on rsp_ squeezes out bubbles and reaches req_stall only once all are full.
module personal_id_validator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pid_pkg::PID_IN_W-1:0]   req_id_number,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_valid_res,
   output logic [6:0]                     rsp_birth_day,
   output logic [5:0]                     rsp_birth_month,
   output logic [11:0]                    rsp_birth_year,
   output logic                           rsp_is_female
);

   // Converter chain links; link zero is the incoming item
   logic                  conv_valid [0:pid_pkg::PID_BCD_STAGES];
   logic                  conv_ready [0:pid_pkg::PID_BCD_STAGES];
   pid_pkg::pid_conv_type conv_data  [0:pid_pkg::PID_BCD_STAGES];

   logic                  dec_valid;
   logic                  dec_ready;
   pid_pkg::pid_dec_type  dec_data;

   logic                  cen_valid;
   logic                  cen_ready;
   pid_pkg::pid_cen_type  cen_data;

   pid_pkg::pid_res_type  res_data;

   // Pad the number with leading zeros and start with an empty digit field
   assign conv_valid[0]    = req_valid;
   assign conv_data[0].bin = pid_pkg::PID_BIN_W'(req_id_number);
   assign conv_data[0].bcd = '0;
   assign req_stall        = !conv_ready[0];

   for (genvar g = 0; g < pid_pkg::PID_BCD_STAGES; g++) begin : g_conv
      pid_bcd_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (conv_valid[g]),
         .up_data    (conv_data[g]),
         .up_ready   (conv_ready[g]),
         .down_valid (conv_valid[g+1]),
         .down_data  (conv_data[g+1]),
         .down_ready (conv_ready[g+1])
      );
   end

   // Split the low ten decimal digits into fields and the weighted sum; drop the eleventh
   pid_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (conv_valid[pid_pkg::PID_BCD_STAGES]),
      .up_data    (conv_data[pid_pkg::PID_BCD_STAGES]),
      .up_ready   (conv_ready[pid_pkg::PID_BCD_STAGES]),
      .down_valid (dec_valid),
      .down_data  (dec_data),
      .down_ready (dec_ready)
   );

   // Remove the century offset from the month and form the mod-11 quotient
   pid_century u_century (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (dec_valid),
      .up_data    (dec_data),
      .up_ready   (dec_ready),
      .down_valid (cen_valid),
      .down_data  (cen_data),
      .down_ready (cen_ready)
   );

   // Judge date and check digit; this register drives the rsp_ ports directly
   pid_verdict u_verdict (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (cen_valid),
      .up_data    (cen_data),
      .up_ready   (cen_ready),
      .down_valid (rsp_valid),
      .down_data  (res_data),
      .down_ready (!rsp_stall)
   );

   assign rsp_valid_res   = res_data.valid_res;
   assign rsp_birth_day   = res_data.day;
   assign rsp_birth_month = res_data.month;
   assign rsp_birth_year  = res_data.year;
   assign rsp_is_female   = res_data.female;

endmodule

[tb/personal_id_validator_unit_test.sv]
// Self-checking bench for personal_id_validator_unit: an in-bench decoder of the
// identity number predicts every result. Directed dates and random numbers, with back-pressure.
// Depends only on the personal_id_validator_unit RTL.
module personal_id_validator_unit_test;

   localparam longint unsigned TEN_DIGITS = 64'd10_000_000_000;

   // One predicted or observed result item
   typedef struct packed {
      logic        ok;
      logic [6:0]  day;
      logic [5:0]  month;
      logic [11:0] year;
      logic        female;
   } id_verdict_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [33:0] req_id_number = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_valid_res;
   logic [6:0]  rsp_birth_day;
   logic [5:0]  rsp_birth_month;
   logic [11:0] rsp_birth_year;
   logic        rsp_is_female;

   // Verdicts for items already offered, oldest first
   id_verdict_t pending_verdicts[$];
   int          items_sent = 0;
   int          results_seen = 0;
   int          mismatches = 0;
   bit          idle_on = 1'b1;       // random gaps on both channels
   bit          long_hold_req = 1'b0; // ask the receiver for one long stall
   int          long_hold_len = 0;

   personal_id_validator_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_id_number   (req_id_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_birth_day   (rsp_birth_day),
      .rsp_birth_month (rsp_birth_month),
      .rsp_birth_year  (rsp_birth_year),
      .rsp_is_female   (rsp_is_female)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Weight of digit pos (0 is the most significant) in the check sum
   function automatic int unsigned check_weight(input int unsigned pos);
      case (pos)
         0: return 2;
         1: return 4;
         2: return 8;
         3: return 5;
         4: return 10;
         5: return 9;
         6: return 7;
         7: return 3;
         default: return 6;
      endcase
   endfunction

   // Weighted sum of the first nine digits modulo 11, before ten is folded to zero
   function automatic int unsigned weighted_rem(input longint unsigned first9);
      longint unsigned v;
      int unsigned     sum;
      v = first9;
      sum = 0;
      for (int i = 8; i >= 0; i--) begin
         sum += check_weight(i) * int'(v % 10);
         v /= 10;
      end
      return sum % 11;
   endfunction

   function automatic bit is_leap_year(input int unsigned yr);
      return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
   endfunction

   // Predict the result item for one identity number
   function automatic id_verdict_t decode_egn(input logic [33:0] id);
      longint unsigned v;
      int unsigned     dg [10];
      int unsigned     yr, mon, dy, lim, rem;
      id_verdict_t     r;
      // only the low ten decimal digits count
      v = {30'd0, id} % TEN_DIGITS;
      rem = weighted_rem(v / 10);
      if (rem == 10) rem = 0;
      for (int i = 9; i >= 0; i--) begin
         dg[i] = int'(v % 10);
         v /= 10;
      end
      yr  = dg[0] * 10 + dg[1];
      mon = dg[2] * 10 + dg[3];
      dy  = dg[4] * 10 + dg[5];
      // century is carried in the month code
      if (mon > 40) begin
         mon -= 40;
         yr += 2000;
      end else if (mon > 20) begin
         mon -= 20;
         yr += 1800;
      end else begin
         yr += 1900;
      end
      case (mon)
         1, 3, 5, 7, 8, 10, 12: lim = 31;
         4, 6, 9, 11:           lim = 30;
         2:                     lim = is_leap_year(yr) ? 29 : 28;
         default:               lim = 0;   // bad month never passes
      endcase
      r.ok     = (dy != 0) && (dy <= lim) && (dg[9] == rem);
      r.day    = 7'(dy);
      r.month  = 6'(mon);
      r.year   = 12'(yr);
      r.female = 1'(dg[8] & 1);
      return r;
   endfunction

   // Assemble a number from two-digit year, encoded month, day and serial,
   // with a correct check digit
   function automatic logic [33:0] build_id(input int unsigned yy, input int unsigned mm,
                                            input int unsigned dd, input int unsigned serial);
      longint unsigned first9;
      int unsigned     rem;
      first9 = longint'(yy) * 10_000_000 + longint'(mm) * 100_000 + longint'(dd) * 1000
               + longint'(serial);
      rem = weighted_rem(first9);
      if (rem == 10) rem = 0;
      return 34'(first9 * 10 + rem);
   endfunction

   // Change the last digit only, so the check digit no longer matches
   function automatic logic [33:0] corrupt_check(input logic [33:0] id);
      return (id % 10 == 9) ? id - 34'd9 : id + 34'd1;
   endfunction

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly well-formed numbers with random dates; the rest raw noise, over 34 bits or within ten digits
   function automatic logic [33:0] random_id();
      int unsigned     r, mon, dy;
      longint unsigned raw;
      logic [33:0]     id;
      r = $urandom_range(0, 99);
      raw = {$urandom, $urandom};
      if (r < 15) return raw[33:0];
      if (r < 30) return 34'(raw % TEN_DIGITS);
      mon = $urandom_range(1, 12) + 20 * $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 85) dy = $urandom_range(1, 28);
      else if (r < 97) dy = $urandom_range(29, 31);
      else dy = $urandom_range(0, 1) ? 0 : $urandom_range(32, 99);
      id = build_id($urandom_range(0, 99), mon, dy, $urandom_range(0, 999));
      if ($urandom_range(0, 99) < 15) id = corrupt_check(id);
      return id;
   endfunction

   // Offer one item and hold it until it is taken. Stall is sampled at the falling
   // edge, so the decision never races the rising edge that takes the item.
   task automatic send_id(input logic [33:0] id);
      int gap;
      bit taken;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_id_number <= id;
      pending_verdicts.push_back(decode_egn(id));
      items_sent++;
      do begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         @(posedge clock);
      end while (!taken);
   endtask

   // Drop valid and hold off until every outstanding result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
   endtask

   task automatic log_mismatch(input string why, input id_verdict_t want,
                               input id_verdict_t got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: want ok=%0b day=%0d month=%0d year=%0d female=%0b", why,
                  want.ok, want.day, want.month, want.year, want.female);
      if (mismatches <= 10)
         $display("   got ok=%0b day=%0d month=%0d year=%0d female=%0b",
                  got.ok, got.day, got.month, got.year, got.female);
   endtask

   // Field extremes and numbers wider than ten digits
   task automatic test_extremes();
      send_id(34'd0);
      send_id(34'd9_999_999_999);
      send_id('1);
      send_id(34'(TEN_DIGITS) + build_id(15, 7, 4, 321));
   endtask

   // The three centuries and month codes that fall outside every century
   task automatic test_centuries();
      send_id(build_id(50, 23, 15, 100));  // 1800s
      send_id(build_id(75, 7, 4, 201));    // 1900s
      send_id(build_id(12, 50, 10, 302));  // 2000s, October
      send_id(build_id(0, 20, 10, 403));   // raw 20 stays in the 1900s, month 20
      send_id(build_id(0, 40, 10, 504));   // raw 40 means 1800s, month 20
      send_id(build_id(30, 0, 10, 605));   // month zero
      send_id(build_id(30, 13, 10, 706));  // month thirteen
      send_id(build_id(30, 53, 10, 807));  // 2000s, month thirteen
      send_id(build_id(99, 99, 99, 999));  // highest month and day codes
   endtask

   // Month lengths and the leap-year rule, day zero included
   task automatic test_month_lengths();
      send_id(build_id(0, 42, 29, 111));   // 2000 is a leap year
      send_id(build_id(0, 2, 29, 112));    // 1900 is not
      send_id(build_id(0, 2, 28, 113));
      send_id(build_id(4, 42, 29, 114));
      send_id(build_id(96, 22, 29, 115));  // 1896
      send_id(build_id(85, 4, 31, 116));   // April has thirty days
      send_id(build_id(85, 4, 30, 117));
      send_id(build_id(99, 52, 31, 118));  // last day of 2099
      send_id(build_id(85, 1, 0, 119));    // day zero
   endtask

   // Check digit: remainder ten folded to zero, a wrong digit, both sexes
   task automatic test_check_digit();
      int unsigned s;
      for (s = 0; s < 999; s++)
         if (weighted_rem(longint'(88) * 10_000_000 + 5 * 100_000 + 17 * 1000 + s) == 10)
            break;
      send_id(build_id(88, 5, 17, s));
      send_id(corrupt_check(build_id(88, 5, 17, 240)));
      send_id(build_id(91, 11, 3, 123));   // odd ninth digit
      send_id(build_id(91, 11, 3, 124));
   endtask

   // Bulk random items, with one stretch where neither side idles
   task automatic test_random_mix();
      for (int i = 0; i < 1150; i++) begin
         idle_on = !(i >= 600 && i < 750);
         send_id(random_id());
      end
      idle_on = 1'b1;
   endtask

   // Hold the output for a long time while items keep coming, so the
   // pipeline fills and pushes back on the input
   task automatic test_long_hold();
      idle_on       = 1'b0;
      long_hold_len = 300;
      long_hold_req = 1'b1;
      for (int i = 0; i < 60; i++) send_id(random_id());
      idle_on = 1'b1;
   endtask

   // Let the block run dry in the middle of the stream, then restart it
   task automatic test_drain_pause();
      for (int i = 0; i < 40; i++) send_id(random_id());
      wait_drained();
      for (int i = 0; i < 40; i++) send_id(random_id());
   endtask

   // Receiver: random stall pattern, or one long hold when asked for it
   initial begin
      int run;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            for (int k = 0; k < long_hold_len; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end else if (!idle_on) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            run = $urandom_range(1, 8);
            repeat (run) begin
               rsp_stall <= 1'b0;
               @(posedge clock);
            end
            run = pick_gap();
            repeat (run) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
      end
   end

   // Result checker: a result is taken at the next rising edge when valid is
   // high and stall low; compare it against the oldest prediction
   always @(negedge clock) begin
      id_verdict_t want, got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = {rsp_valid_res, rsp_birth_day, rsp_birth_month, rsp_birth_year,
                rsp_is_female};
         results_seen++;
         if (pending_verdicts.size() == 0) begin
            log_mismatch("result with nothing outstanding", '0, got);
         end else begin
            want = pending_verdicts.pop_front();
            if (got !== want) log_mismatch("result mismatch", want, got);
         end
      end
   end

   // Main sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_centuries();
      test_month_lengths();
      test_check_digit();
      test_random_mix();
      test_long_hold();
      test_drain_pause();
      wait_drained();
      // allow for the nine pipeline stages and then some, to catch stray results
      repeat (30) @(posedge clock);
      $display("%0d items, %0d results, %0d mismatches", items_sent, results_seen,
               mismatches);
      $display("covered: three centuries, leap Februaries, bad dates, check digits, stalls");
      if (mismatches == 0 && pending_verdicts.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/pid_pkg.sv
rtl/core/pid_bcd_stage.sv
rtl/core/pid_decode.sv
rtl/core/pid_century.sv
rtl/core/pid_verdict.sv
rtl/core/personal_id_validator_unit.sv
tb/personal_id_validator_unit_test.sv
